>>> hdl/wcsn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcsn_pkg - shared types and constants for the channel state / NAV tracker
// Event codes, NAV event codes, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package wcsn_pkg;

    localparam int TIME_BITS_DEF = 16;
    localparam int ADDR_BITS_DEF = 48;

    localparam int DUR_W    = 16;
    localparam int RSS_W    = 16;
    localparam int TA_W     = 48;
    localparam int CNT_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 6;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 3;

    typedef enum logic [2:0] {
        EV_TICK     = 3'd0,
        EV_TX_START = 3'd1,
        EV_TX_END   = 3'd2,
        EV_RX_START = 3'd3,
        EV_RX_END   = 3'd4,
        EV_RSS      = 3'd5,
        EV_FRAME    = 3'd6
    } event_kind_t;

    typedef enum logic [1:0] {
        NAV_NONE  = 2'd0,
        NAV_SET   = 2'd1,
        NAV_ENDED = 2'd2
    } nav_event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHY_CS_THRESHOLD = 3'd0,
        REG_SIFS_TIME        = 3'd1,
        REG_REPORT_PERIOD    = 3'd2,
        REG_USE_OWN_TX       = 3'd3,
        REG_USE_OWN_RX       = 3'd4,
        REG_USE_PHY_CS       = 3'd5,
        REG_USE_NAV          = 3'd6
    } reg_index_t;

    localparam logic [RSS_W-1:0] PHY_CS_THRESHOLD_RST = 16'd0;
    localparam logic [DUR_W-1:0] SIFS_TIME_RST        = 16'd16;
    localparam logic [CNT_W-1:0] REPORT_PERIOD_RST    = 24'd1000000;
    localparam logic [CNT_W-1:0] CNT_MAX              = {CNT_W{1'b1}};

endpackage

>>> hdl/wlan_channel_state_nav_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlan_channel_state_nav_tracker - clear channel assessment with NAV
// Tracks own tx/rx, signal level, NAV countdown and busy-time per period.
// ----------------------------------------------------------------------------
// One event beat is taken per clock cycle and each produces exactly one result
// beat, in the next cycle, from a single output register. The event is decoded
// and the state updated by flat compare and count logic in the accepting cycle;
// s_tready stays high while the output register is empty or being drained, so
// the sustained rate is one beat per cycle unless the result side stalls.
// Configuration writes land at once and are meant to be issued while idle.
module wlan_channel_state_nav_tracker #(
    parameter int TIME_BITS = wcsn_pkg::TIME_BITS_DEF,
    parameter int ADDR_BITS = wcsn_pkg::ADDR_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // config write port
    input  logic                               cfg_wr_en,
    input  logic [wcsn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wcsn_pkg::CFG_DAT_W-1:0]     cfg_wdata,
    // event channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // frame_duration[15:0], reply_timeout[31:16], transmitter_address[79:32],
    // rss_level[95:80]
    input  logic [wcsn_pkg::S_TDATA_W-1:0]     s_tdata,
    // kind[2:0], is_preamble[3], for_me[4], is_rts[5]
    input  logic [wcsn_pkg::S_TUSER_W-1:0]     s_tuser,
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // channel_busy[0], busy_changed[1], nav_address[49:2], busy_ticks[73:50],
    // zero fill[79:74]
    output logic [wcsn_pkg::M_TDATA_W-1:0]     m_tdata,
    // nav_event[1:0], report_valid[2]
    output logic [wcsn_pkg::M_TUSER_W-1:0]     m_tuser
);
    import wcsn_pkg::*;

    localparam int DW = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
    localparam int AW = (ADDR_BITS < TA_W) ? ADDR_BITS : TA_W;
    localparam logic [DW-1:0]   TIME_MAX_W = DW'({TIME_BITS{1'b1}});
    localparam logic [TA_W-1:0] ADDR_MASK  = TA_W'({AW{1'b1}});

    // configuration
    logic [RSS_W-1:0] phy_cs_threshold_reg;
    logic [DUR_W-1:0] sifs_time_reg;
    logic [CNT_W-1:0] report_period_reg;
    logic             use_own_tx_reg, use_own_rx_reg, use_phy_cs_reg, use_nav_reg;

    // tracker state
    logic [TIME_BITS-1:0] nav_left_reg, nav_left_next;
    logic                 awaiting_reply_reg, awaiting_reply_next;
    logic                 tx_active_reg, tx_active_next;
    logic                 rx_active_reg, rx_active_next;
    logic [RSS_W-1:0]     rss_now_reg, rss_now_next;
    logic                 last_busy_reg, busy_next;
    logic [CNT_W-1:0]     busy_accum_reg, busy_accum_next;
    logic [CNT_W-1:0]     period_count_reg, period_count_next;

    // result register
    logic                 m_tvalid_reg;
    logic                 busy_out_reg, changed_out_reg;
    nav_event_t           nav_ev_reg, nav_ev_next;
    logic [TA_W-1:0]      nav_addr_reg, nav_addr_next;
    logic                 rep_reg, rep_next;
    logic [CNT_W-1:0]     ticks_reg, ticks_next;

    // unpacked input fields
    event_kind_t          kind;
    logic [DUR_W-1:0]     fdur_raw, rto_raw, rss_in;
    logic [TA_W-1:0]      ta;
    logic                 is_pre, for_me, is_rts;
    logic [DW-1:0]        fdur_w, rto_w;
    logic [TIME_BITS-1:0] fdur, rto, dur_foreign;
    logic [CNT_W-1:0]     period, count_inc;
    logic                 accept;

    assign kind     = event_kind_t'(s_tuser[2:0]);
    assign is_pre   = s_tuser[3];
    assign for_me   = s_tuser[4];
    assign is_rts   = s_tuser[5];
    assign fdur_raw = s_tdata[15:0];
    assign rto_raw  = s_tdata[31:16];
    assign ta       = s_tdata[79:32];
    assign rss_in   = s_tdata[95:80];

    // clamp durations to the NAV counter range
    assign fdur_w = DW'(fdur_raw);
    assign rto_w  = DW'(rto_raw);
    assign fdur   = TIME_BITS'((fdur_w > TIME_MAX_W) ? TIME_MAX_W : fdur_w);
    assign rto    = TIME_BITS'((rto_w > TIME_MAX_W) ? TIME_MAX_W : rto_w);
    assign dur_foreign = is_rts ? rto : fdur;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign period    = (report_period_reg == '0) ? CNT_W'(1) : report_period_reg;
    assign count_inc = (period_count_reg != CNT_MAX) ? period_count_reg + CNT_W'(1)
                                                     : period_count_reg;

    always_comb begin
        nav_left_next       = nav_left_reg;
        awaiting_reply_next = awaiting_reply_reg;
        tx_active_next      = tx_active_reg;
        rx_active_next      = rx_active_reg;
        rss_now_next        = rss_now_reg;
        busy_accum_next     = busy_accum_reg;
        period_count_next   = period_count_reg;
        nav_ev_next         = NAV_NONE;
        nav_addr_next       = '0;
        rep_next            = 1'b0;
        ticks_next          = '0;

        case (kind)
            EV_TICK: begin
                if (last_busy_reg && busy_accum_reg != CNT_MAX) begin
                    busy_accum_next = busy_accum_reg + CNT_W'(1);
                end
                if (nav_left_reg != '0) begin
                    nav_left_next = nav_left_reg - TIME_BITS'(1);
                    if (nav_left_reg == TIME_BITS'(1)) begin
                        awaiting_reply_next = 1'b0;
                        nav_ev_next         = NAV_ENDED;
                    end
                end
                period_count_next = count_inc;
                if (count_inc >= period) begin
                    rep_next          = 1'b1;
                    ticks_next        = busy_accum_next;
                    busy_accum_next   = '0;
                    period_count_next = '0;
                end
            end
            EV_TX_START: tx_active_next = 1'b1;
            EV_TX_END: begin
                tx_active_next = 1'b0;
                // hold off the medium for the expected reply
                if ((fdur_raw > sifs_time_reg || rto != '0) && rto > nav_left_reg) begin
                    nav_left_next       = rto;
                    awaiting_reply_next = 1'b1;
                end
            end
            EV_RX_START: rx_active_next = 1'b1;
            EV_RX_END:   rx_active_next = 1'b0;
            EV_RSS: begin
                if (use_phy_cs_reg) begin
                    rss_now_next = rss_in;
                end
            end
            EV_FRAME: begin
                if (is_pre) begin
                    if (fdur > nav_left_reg) begin
                        nav_left_next = fdur;
                    end
                end else if (for_me) begin
                    // the awaited reply arrived: drop our own reservation
                    if (awaiting_reply_reg) begin
                        nav_left_next       = '0;
                        awaiting_reply_next = 1'b0;
                    end
                end else if ((is_rts || fdur_raw >= sifs_time_reg)
                             && dur_foreign > nav_left_reg) begin
                    nav_left_next = dur_foreign;
                    nav_ev_next   = NAV_SET;
                    nav_addr_next = ta & ADDR_MASK;
                end
            end
            default: ;
        endcase

        busy_next = (use_own_tx_reg && tx_active_next)
                 || (use_own_rx_reg && rx_active_next)
                 || (use_phy_cs_reg && rss_now_next > phy_cs_threshold_reg)
                 || (use_nav_reg && nav_left_next != '0);
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phy_cs_threshold_reg <= PHY_CS_THRESHOLD_RST;
            sifs_time_reg        <= SIFS_TIME_RST;
            report_period_reg    <= REPORT_PERIOD_RST;
            use_own_tx_reg       <= 1'b1;
            use_own_rx_reg       <= 1'b1;
            use_phy_cs_reg       <= 1'b1;
            use_nav_reg          <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_index))
                REG_PHY_CS_THRESHOLD: phy_cs_threshold_reg <= cfg_wdata[RSS_W-1:0];
                REG_SIFS_TIME:        sifs_time_reg        <= cfg_wdata[DUR_W-1:0];
                REG_REPORT_PERIOD:    report_period_reg    <= cfg_wdata[CNT_W-1:0];
                REG_USE_OWN_TX:       use_own_tx_reg       <= cfg_wdata[0];
                REG_USE_OWN_RX:       use_own_rx_reg       <= cfg_wdata[0];
                REG_USE_PHY_CS:       use_phy_cs_reg       <= cfg_wdata[0];
                REG_USE_NAV:          use_nav_reg          <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // tracker state, advance on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nav_left_reg       <= '0;
            awaiting_reply_reg <= 1'b0;
            tx_active_reg      <= 1'b0;
            rx_active_reg      <= 1'b0;
            rss_now_reg        <= '0;
            last_busy_reg      <= 1'b0;
            busy_accum_reg     <= '0;
            period_count_reg   <= '0;
        end else if (accept) begin
            nav_left_reg       <= nav_left_next;
            awaiting_reply_reg <= awaiting_reply_next;
            tx_active_reg      <= tx_active_next;
            rx_active_reg      <= rx_active_next;
            rss_now_reg        <= rss_now_next;
            last_busy_reg      <= busy_next;
            busy_accum_reg     <= busy_accum_next;
            period_count_reg   <= period_count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            busy_out_reg    <= busy_next;
            changed_out_reg <= busy_next != last_busy_reg;
            nav_ev_reg      <= nav_ev_next;
            nav_addr_reg    <= nav_addr_next;
            rep_reg         <= rep_next;
            ticks_reg       <= ticks_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, ticks_reg, nav_addr_reg, changed_out_reg, busy_out_reg};
    assign m_tuser  = {rep_reg, nav_ev_reg};

endmodule

>>> tb/wcsn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcsn_checker - result predictor and scoreboard for the channel state tracker
// Mirrors register writes and accepted event beats into its own copy of the
// tracker state, queues the expected result of each event and compares every
// accepted result beat field by field against the oldest queued expectation.
// ----------------------------------------------------------------------------
module wcsn_checker
    import wcsn_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DAT_W-1:0]   cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [S_TUSER_W-1:0]   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic [M_TUSER_W-1:0]   m_tuser,
    output int                     fail_count,
    output int                     outstanding,
    output int                     result_count,
    output int                     report_count
);

    typedef struct packed {
        logic             busy;
        logic             changed;
        nav_event_t       nav_ev;
        logic [TA_W-1:0]  nav_addr;
        logic             rep;
        logic [CNT_W-1:0] ticks;
    } chan_result_t;

    // register copy
    logic [RSS_W-1:0] cs_threshold;
    logic [DUR_W-1:0] sifs;
    logic [CNT_W-1:0] period_len;
    logic             en_tx, en_rx, en_cs, en_nav;

    // tracker state
    logic [DUR_W-1:0] nav_left;
    logic             awaiting, tx_on, rx_on, busy_prev;
    logic [RSS_W-1:0] rss_now;
    logic [CNT_W-1:0] busy_acc, period_cnt;

    chan_result_t channel_results_q[$];

    function automatic chan_result_t track_event(input logic [S_TDATA_W-1:0] d,
                                                 input logic [S_TUSER_W-1:0] u);
        logic [2:0]       kind;
        logic [DUR_W-1:0] fdur, rto, dur;
        logic [TA_W-1:0]  ta;
        logic [RSS_W-1:0] rss;
        logic             pre, me, rts;
        logic [CNT_W-1:0] per;
        chan_result_t     r;
        fdur = d[15:0];
        rto  = d[31:16];
        ta   = d[79:32];
        rss  = d[95:80];
        kind = u[2:0];
        pre  = u[3];
        me   = u[4];
        rts  = u[5];
        r = '0;
        case (kind)
            EV_TICK: begin
                // the tick is busy if the channel was busy going into it
                if (busy_prev && busy_acc != CNT_MAX) busy_acc = busy_acc + 1'b1;
                if (nav_left != '0) begin
                    nav_left = nav_left - 1'b1;
                    if (nav_left == '0) begin
                        awaiting = 1'b0;
                        r.nav_ev = NAV_ENDED;
                    end
                end
                per = (period_len == '0) ? 24'd1 : period_len;
                if (period_cnt != CNT_MAX) period_cnt = period_cnt + 1'b1;
                if (period_cnt >= per) begin
                    r.rep      = 1'b1;
                    r.ticks    = busy_acc;
                    busy_acc   = '0;
                    period_cnt = '0;
                end
            end
            EV_TX_START: tx_on = 1'b1;
            EV_TX_END: begin
                tx_on = 1'b0;
                if ((fdur > sifs || rto != '0) && rto > nav_left) begin
                    nav_left = rto;
                    awaiting = 1'b1;
                end
            end
            EV_RX_START: rx_on = 1'b1;
            EV_RX_END:   rx_on = 1'b0;
            EV_RSS: if (en_cs) rss_now = rss;
            EV_FRAME: begin
                if (pre) begin
                    if (fdur > nav_left) nav_left = fdur;
                end else if (me) begin
                    // reply arrived: cancel our own reservation silently
                    if (awaiting) begin
                        nav_left = '0;
                        awaiting = 1'b0;
                    end
                end else begin
                    dur = rts ? rto : fdur;
                    if ((rts || fdur >= sifs) && dur > nav_left) begin
                        nav_left   = dur;
                        r.nav_ev   = NAV_SET;
                        r.nav_addr = ta;
                    end
                end
            end
            default: ;
        endcase
        r.busy = (en_tx && tx_on) || (en_rx && rx_on) ||
                 (en_cs && rss_now > cs_threshold) || (en_nav && nav_left != '0);
        r.changed = (r.busy != busy_prev);
        busy_prev = r.busy;
        return r;
    endfunction

    always @(posedge aclk) begin
        chan_result_t got, want;
        if (!aresetn) begin
            cs_threshold = PHY_CS_THRESHOLD_RST;
            sifs         = SIFS_TIME_RST;
            period_len   = REPORT_PERIOD_RST;
            en_tx        = 1'b1;
            en_rx        = 1'b1;
            en_cs        = 1'b1;
            en_nav       = 1'b1;
            nav_left     = '0;
            awaiting     = 1'b0;
            tx_on        = 1'b0;
            rx_on        = 1'b0;
            rss_now      = '0;
            busy_prev    = 1'b0;
            busy_acc     = '0;
            period_cnt   = '0;
            channel_results_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PHY_CS_THRESHOLD: cs_threshold = cfg_wdata[RSS_W-1:0];
                    REG_SIFS_TIME:        sifs         = cfg_wdata[DUR_W-1:0];
                    REG_REPORT_PERIOD:    period_len   = cfg_wdata[CNT_W-1:0];
                    REG_USE_OWN_TX:       en_tx        = cfg_wdata[0];
                    REG_USE_OWN_RX:       en_rx        = cfg_wdata[0];
                    REG_USE_PHY_CS:       en_cs        = cfg_wdata[0];
                    REG_USE_NAV:          en_nav       = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                channel_results_q.push_back(track_event(s_tdata, s_tuser));
            if (m_tvalid && m_tready) begin
                got.busy     = m_tdata[0];
                got.changed  = m_tdata[1];
                got.nav_addr = m_tdata[49:2];
                got.ticks    = m_tdata[73:50];
                got.nav_ev   = nav_event_t'(m_tuser[1:0]);
                got.rep      = m_tuser[2];
                result_count++;
                if (got.rep) report_count++;
                if (channel_results_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("[%0t] unexpected result beat: busy %b nav %0d report %b",
                                 $realtime, got.busy, got.nav_ev, got.rep);
                    fail_count++;
                end else begin
                    want = channel_results_q.pop_front();
                    if (got.busy !== want.busy || got.changed !== want.changed ||
                        got.nav_ev !== want.nav_ev || got.nav_addr !== want.nav_addr ||
                        got.rep !== want.rep || got.ticks !== want.ticks) begin
                        if (fail_count < 10) begin
                            $display("[%0t] result %0d mismatch (exp/act): busy %b/%b %s",
                                     $realtime, result_count, want.busy, got.busy, "");
                            $display("    changed %b/%b nav %0d/%0d addr %h/%h",
                                     want.changed, got.changed, want.nav_ev, got.nav_ev,
                                     want.nav_addr, got.nav_addr);
                            $display("    report %b/%b ticks %0d/%0d",
                                     want.rep, got.rep, want.ticks, got.ticks);
                        end
                        fail_count++;
                    end
                end
            end
        end
        outstanding <= channel_results_q.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - stimulus and verdict for the channel state / NAV tracker
// Runs a directed event sequence and then shaped random traffic (transmit
// exchanges, overheard frames, level changes, tick bursts, noise) under eight
// register settings with varying source gaps and result-side backpressure.
// ----------------------------------------------------------------------------
module tb_top;
    import wcsn_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 190;
    localparam int DRAIN_CYCLES  = 20;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tready  = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int fail_count, outstanding, result_count, report_count;

    int         src_idle_pct  = 0;
    int         snk_stall_pct = 0;
    logic       hold_req      = 1'b0;
    logic       hold_done     = 1'b0;
    int         hold_left     = 0;
    int         cycle_count   = 0;
    int         items_sent    = 0;
    logic [15:0] sifs_now     = 16'd16;
    logic [15:0] thr_now      = 16'd0;

    wlan_channel_state_nav_tracker uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    wcsn_checker scoreboard (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .result_count (result_count),
        .report_count (report_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls, plus one long hold-off to back up the block
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    function automatic logic [15:0] rnd16();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [47:0] rnd48();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[47:0];
    endfunction

    function automatic logic rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    // mostly short durations so NAV runs out within a tick burst
    function automatic logic [15:0] pick_dur();
        int sel;
        sel = $urandom_range(0, 39);
        if (sel == 0) return 16'd0;
        else if (sel == 1) return 16'hFFFF;
        else if (sel == 2) return rnd16();
        else if (sel < 7) return sifs_now + 16'($urandom_range(0, 2)) - 16'd1;
        else return 16'($urandom_range(1, 40));
    endfunction

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return thr_now + 16'($urandom_range(0, 2)) - 16'd1;
            default: return rnd16();
        endcase
    endfunction

    task automatic send_event(input logic [2:0] kind, input logic [15:0] fdur,
                              input logic [15:0] rto, input logic pre, input logic me,
                              input logic rts, input logic [47:0] ta,
                              input logic [15:0] rss);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rss, ta, rto, fdur};
        s_tuser  <= {rts, me, pre, kind};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // fields the kind does not use carry random noise
    task automatic send_simple(input logic [2:0] kind);
        send_event(kind, rnd16(), rnd16(), rbit(), rbit(), rbit(), rnd48(), rnd16());
    endtask

    task automatic send_frame(input logic [15:0] fdur, input logic [15:0] rto,
                              input logic pre, input logic me, input logic rts);
        send_event(EV_FRAME, fdur, rto, pre, me, rts, rnd48(), rnd16());
    endtask

    task automatic tick_burst(input int n);
        repeat (n) send_simple(EV_TICK);
    endtask

    // hold the input idle until every result is back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [15:0] thr, input logic [15:0] sifs,
                                 input logic [23:0] per, input logic tx, input logic rx,
                                 input logic cs, input logic nav);
        reg_index_t idx [7] = '{REG_PHY_CS_THRESHOLD, REG_SIFS_TIME, REG_REPORT_PERIOD,
                                REG_USE_OWN_TX, REG_USE_OWN_RX, REG_USE_PHY_CS,
                                REG_USE_NAV};
        logic [23:0] val [7];
        val = '{24'(thr), 24'(sifs), per, 24'(tx), 24'(rx), 24'(cs), 24'(nav)};
        settle();
        for (int i = 0; i < 7; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        thr_now  = thr;
        sifs_now = sifs;
    endtask

    task automatic run_directed();
        send_event(EV_RSS, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 48'd0, 16'hFFFF);
        send_event(EV_RSS, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 48'd0, 16'd0);
        send_event(EV_TX_START, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, '1, 16'hFFFF);
        send_simple(EV_TICK);
        // own exchange with the longest reply timeout, then the reply cancels it
        send_event(EV_TX_END, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 48'd0, 16'd0);
        send_frame(16'd5, 16'd5, 1'b0, 1'b1, 1'b0);
        // duration at sifs and no timeout: no reservation
        send_event(EV_TX_END, 16'd16, 16'd0, 1'b0, 1'b0, 1'b0, 48'd0, 16'd0);
        send_event(EV_TX_END, 16'd17, 16'd3, 1'b0, 1'b0, 1'b0, 48'd0, 16'd0);
        tick_burst(3);
        send_simple(EV_RX_START);
        // preamble wins over for_me and rts
        send_frame(16'd2, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        send_simple(EV_RX_END);
        tick_burst(2);
        send_frame(16'd15, 16'd100, 1'b0, 1'b0, 1'b0);
        send_event(EV_FRAME, 16'd40000, 16'd0, 1'b0, 1'b0, 1'b0, '1, 16'd0);
        send_frame(16'd50000, 16'd0, 1'b0, 1'b0, 1'b1);
        send_event(EV_TX_END, 16'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0, 48'd0, 16'd0);
        send_frame(16'd0, 16'd0, 1'b0, 1'b1, 1'b0);
        send_event(3'd7, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, '1, 16'hFFFF);
        send_event(EV_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 48'd0, 16'd0);
        send_event(EV_FRAME, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 48'd0, 16'd0);
    endtask

    task automatic run_random(input int count);
        int start;
        logic [15:0] rto;
        start = items_sent;
        while (items_sent - start < count) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    // own exchange: transmit, wait for the reply, maybe get it
                    send_simple(EV_TX_START);
                    tick_burst($urandom_range(0, 4));
                    rto = ($urandom_range(0, 5) == 0) ? 16'hFFFF : pick_dur();
                    send_event(EV_TX_END, pick_dur(), rto, rbit(), rbit(), rbit(),
                               rnd48(), rnd16());
                    tick_burst($urandom_range(0, 8));
                    if ($urandom_range(0, 3) != 0) send_frame(pick_dur(), pick_dur(),
                                                              1'b0, 1'b1, rbit());
                    tick_burst($urandom_range(0, 6));
                end
                2, 3: begin
                    // overheard exchange between other stations
                    send_simple(EV_RX_START);
                    if (rbit()) send_frame(pick_dur(), pick_dur(), 1'b1, rbit(), rbit());
                    tick_burst($urandom_range(0, 3));
                    send_frame(pick_dur(), pick_dur(), 1'b0, 1'b0, rbit());
                    send_simple(EV_RX_END);
                    tick_burst($urandom_range(1, 30));
                end
                4: begin
                    send_event(EV_RSS, rnd16(), rnd16(), rbit(), rbit(), rbit(),
                               rnd48(), pick_level());
                    tick_burst($urandom_range(0, 5));
                end
                5, 6: tick_burst($urandom_range(1, 20));
                7: send_event(3'($urandom_range(0, 7)), rnd16(), rnd16(), rbit(), rbit(),
                              rbit(), rnd48(), rnd16());
                8: send_event(3'($urandom_range(1, 6)), pick_dur(), pick_dur(), rbit(),
                              rbit(), rbit(), rnd48(), pick_level());
                default: send_simple(EV_TICK);
            endcase
        end
    endtask

    task automatic run_phase(input logic [15:0] thr, input logic [15:0] sifs,
                             input logic [23:0] per, input logic [3:0] uses,
                             input int idle, input int stall);
        apply_setting(thr, sifs, per, uses[3], uses[2], uses[1], uses[0]);
        src_idle_pct = idle;
        snk_stall_pct <= stall;
        run_random(PHASE_ITEMS);
    endtask

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        apply_setting(16'd100, 16'd16, 24'd7, 1'b1, 1'b1, 1'b1, 1'b1);
        run_directed();
        run_random(PHASE_ITEMS);
        run_phase(16'd0,     16'd0,     24'd1,        4'b1011, 72, 0);
        run_phase(16'hFFFF,  16'hFFFF,  24'hFFFFFF,   4'b0101, 0, 72);
        run_phase(16'd30000, 16'd10,    24'd3,        4'b0000, 26, 26);
        hold_req <= 1'b1;
        run_phase(16'd500,   16'd20,    24'd50,       4'b1111, 0, 0);
        // shorter period than the count left running from the last phase
        run_phase(16'd1234,  16'd16,    24'd5,        4'b1110, 72, 0);
        run_phase(16'hFFFE,  16'd1,     24'd2,        4'b0111, 0, 72);
        run_phase(16'd60,    16'd24,    24'd11,       4'b1111, 26, 26);

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d event beats under 8 register settings with gaps and backpressure;",
                 items_sent);
        $display("checked %0d result beats including %0d period reports, %0d mismatches.",
                 result_count, report_count, fail_count);
        if (fail_count == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
